>>> rtl/core/rdfc_pkg.sv
// Package for the damped feedback comb: sizes, register codes, types and arithmetic helpers.
`default_nettype none

package rdfc_pkg;

  localparam int RING_DEPTH  = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(RING_DEPTH);
  localparam int LEN_W       = $clog2(RING_DEPTH + 1);
  localparam int DLEN_W      = 13;
  localparam int GAIN_W      = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  // Product width covers every Q1.15 * Q1.15 * sample term with headroom.
  localparam int PROD_W      = 2 * GAIN_W + SAMPLE_BITS + 4;
  localparam int RND_SHIFT   = 2 * (GAIN_W - 1);
  localparam int RND_W       = PROD_W - RND_SHIFT;
  localparam int SUM_W       = RND_W + 1;

  localparam logic [DLEN_W-1:0] DELAY_LENGTH_RST = DLEN_W'(1024);
  localparam logic [GAIN_W-1:0] GAIN_RST         = GAIN_W'(16384);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GAIN_W-1:0]             gain_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH = CFG_IDX_W'(0),
    CFG_WET_GAIN     = CFG_IDX_W'(1),
    CFG_MIX_GAIN     = CFG_IDX_W'(2),
    CFG_DECAY_GAIN   = CFG_IDX_W'(3),
    CFG_SMOOTH_GAIN  = CFG_IDX_W'(4)
  } cfg_idx_t;

  typedef struct packed {
    logic [DLEN_W-1:0] delay_length;
    gain_t             wet_gain;
    gain_t             mix_gain;
    gain_t             decay_gain;
    gain_t             smoothing_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_SUM,
    ST_MUL2,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic sum;
    logic mul2;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } status_t;

  // Round half up, then drop the Q30 fraction.
  function automatic logic signed [RND_W-1:0] round_shift(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + (PROD_W'(1) <<< (RND_SHIFT - 1));
    return $signed(t[PROD_W-1:RND_SHIFT]);
  endfunction

  function automatic sample_t saturate(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rdfc_if.sv
// Channel interfaces of the comb: input samples, output samples and register writes.
`default_nettype none

interface rdfc_in_if
  import rdfc_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface rdfc_out_if
  import rdfc_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface rdfc_cfg_if
  import rdfc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/reverb_damped_feedback_comb_core.sv
// Top level of the damped feedback comb filter core.
//
// Channel   Direction  Payload                   Transfer when
// in_ch     sink       sample_in  (s16)          in_ch.valid && in_ch.ready
// out_ch    source     sample_out (s16, sat.)    out_ch.valid && out_ch.ready
// cfg_ch    sink       addr (8), data (16)       cfg_ch.valid && cfg_ch.ready
//
// From its transfer, each sample passes through these steps until its result is
// loaded into the output register: the transfer cycle reads the ring RAM, then come
// the wet/mix multiply, the rounding add, the decay multiply and the ring write.
// Because of that chain of dependent multiplies through the ring RAM, a new sample
// is taken only after the last one has been written to the ring.
// Reset is synchronous and active low. The ring reads as zero after reset: a
// fill count marks the written prefix, so no clearing pass is needed.
// A stalled output holds the item in the write step; a new input sample is
// still taken while an earlier result waits in the output register.
`default_nettype none

module reverb_damped_feedback_comb_core
  import rdfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rdfc_cfg_if.sink   cfg_ch,
  rdfc_in_if.sink    in_ch,
  rdfc_out_if.source out_ch
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // Register bank; writes are expected only while the core is idle.
  rdfc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // The controller steps one sample at a time through the datapath.
  rdfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // The datapath holds the ring, the products and the output register.
  rdfc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .in_sample (in_ch.sample_in),
    .out_ch    (out_ch)
  );

  // An accepted sample always moves on to the first multiply.
  a_load_then_mul1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> cmd.mul1)
    else $error("accepted sample did not enter the multiply step");

  // A committed result shows up on the output channel in the next cycle.
  a_commit_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("committed result missing from output register");

  // Only one datapath command is issued per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mul1, cmd.sum, cmd.mul2, cmd.commit}))
    else $error("overlapping datapath commands");

  // The input side is ready only while no sample is in flight.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.mul1 || cmd.sum || cmd.mul2 || cmd.commit))
    else $error("input ready while a sample is in flight");

endmodule

`default_nettype wire

>>> rtl/core/rdfc_ring_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rdfc_ring_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/rdfc_cfg_regs.sv
// Configuration register bank of the comb.
`default_nettype none

module rdfc_cfg_regs
  import rdfc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  rdfc_cfg_if.sink        cfg_ch,
  output cfg_t            cfg
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_length   <= DELAY_LENGTH_RST;
      cfg_r.wet_gain       <= GAIN_RST;
      cfg_r.mix_gain       <= GAIN_RST;
      cfg_r.decay_gain     <= GAIN_RST;
      cfg_r.smoothing_gain <= GAIN_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        CFG_DELAY_LENGTH: cfg_r.delay_length   <= cfg_ch.data[DLEN_W-1:0];
        CFG_WET_GAIN:     cfg_r.wet_gain       <= cfg_ch.data[GAIN_W-1:0];
        CFG_MIX_GAIN:     cfg_r.mix_gain       <= cfg_ch.data[GAIN_W-1:0];
        CFG_DECAY_GAIN:   cfg_r.decay_gain     <= cfg_ch.data[GAIN_W-1:0];
        CFG_SMOOTH_GAIN:  cfg_r.smoothing_gain <= cfg_ch.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/core/rdfc_ctrl.sv
// Sequencing state machine of the comb.
`default_nettype none

module rdfc_ctrl
  import rdfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        // Hold the finished item until the output register is free.
        if (!status.out_blocked) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/rdfc_datapath.sv
// Datapath of the comb: slot logic, ring RAM, multipliers and output register.
`default_nettype none

module rdfc_datapath
  import rdfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  cmd_t       cmd,
  output status_t    status,
  input  sample_t    in_sample,
  rdfc_out_if.source out_ch
);

  localparam int W_W  = GAIN_W + 2;
  localparam int WD_W = W_W + GAIN_W + 1;
  localparam int GW_W = 2 * GAIN_W;

  // Slot bookkeeping. Writes always land at or just past the filled prefix,
  // so a fill count tells which entries still hold their reset value.
  logic [ADDR_W-1:0] pos_r;
  logic [LEN_W-1:0]  fill_r;
  logic [ADDR_W-1:0] slot_r;
  logic              hit_r;

  logic [LEN_W-1:0]  len_eff;
  logic [ADDR_W-1:0] slot;
  logic [LEN_W-1:0]  slot_inc;
  logic [ADDR_W-1:0] pos_nxt;

  always_comb begin
    if (cfg.delay_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(cfg.delay_length) > RING_DEPTH) begin
      len_eff = LEN_W'(RING_DEPTH);
    end else begin
      len_eff = LEN_W'(cfg.delay_length);
    end
    slot     = (LEN_W'(pos_r) >= len_eff) ? '0 : pos_r;
    slot_inc = LEN_W'(slot) + LEN_W'(1);
    pos_nxt  = (slot_inc >= len_eff) ? '0 : slot_inc[ADDR_W-1:0];
  end

  // Gain products depend only on registers and are formed at the transfer.
  logic [GW_W-1:0]        gw_r;
  logic signed [WD_W-1:0] wd_r;
  logic signed [W_W-1:0]  w;
  logic [GW_W-1:0]        gw_nxt;
  logic signed [WD_W-1:0] wd_nxt;

  assign w      = $signed(W_W'(2 ** (GAIN_W - 1))) - $signed({2'b00, cfg.smoothing_gain});
  assign gw_nxt = cfg.wet_gain * cfg.mix_gain;
  assign wd_nxt = w * $signed({1'b0, cfg.decay_gain});

  sample_t x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.load) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= in_sample;
      slot_r <= slot;
      hit_r  <= (LEN_W'(slot) < fill_r);
      gw_r   <= gw_nxt;
      wd_r   <= wd_nxt;
    end
  end

  // Ring memory.
  sample_t rdata;
  sample_t ring_wdata;

  rdfc_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (slot_r),
    .wdata (ring_wdata),
    .re    (cmd.load),
    .raddr (slot),
    .rdata (rdata)
  );

  // Arithmetic stages.
  sample_t                                  ring;
  logic signed [SAMPLE_BITS+GW_W:0]         p_full;
  logic signed [SAMPLE_BITS+GAIN_W:0]       s_full;
  logic signed [PROD_W-1:0]                 p_r;
  logic signed [PROD_W-1:0]                 sr_r;
  logic signed [SUM_W-1:0]                  xsum;
  sample_t                                  y_r;
  sample_t                                  y_nxt;
  logic signed [WD_W+SAMPLE_BITS-1:0]       m_full;
  logic signed [PROD_W-1:0]                 m_r;
  logic signed [PROD_W-1:0]                 q;

  assign ring   = hit_r ? rdata : '0;
  assign p_full = ring * $signed({1'b0, gw_r});
  assign s_full = ring * $signed({1'b0, cfg.smoothing_gain});
  assign xsum   = SUM_W'(x_r) + SUM_W'(round_shift(p_r));
  assign y_nxt  = saturate(xsum);
  assign m_full = wd_r * y_r;
  assign q      = m_r + sr_r;
  assign ring_wdata = saturate(SUM_W'(round_shift(q)));

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p_r  <= PROD_W'(p_full);
      sr_r <= PROD_W'(s_full) <<< (GAIN_W - 1);
    end
    if (cmd.sum) begin
      y_r <= y_nxt;
    end
    if (cmd.mul2) begin
      m_r <= PROD_W'(m_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.commit && (LEN_W'(slot_r) == fill_r)) begin
      fill_r <= fill_r + LEN_W'(1);
    end
  end

  // Output register.
  logic    out_valid_r;
  sample_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= y_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_out  = out_data_r;
  assign status.out_blocked = out_valid_r & ~out_ch.ready;

endmodule

`default_nettype wire
